/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on aclk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication that must hold at every edge out of reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// condition at one edge that demands a past condition
`define ASSERT_PAST(label, cond, past_cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> $past(past_cond)) else $error(msg);

`endif

/* src/swbox_pkg.sv */
// ----------------------------------------------------------------------------
// swbox_pkg
// shared types and constants for the swept box collision timer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swbox_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int STEP_BITS      = 13;
    localparam int HIT_STEP_BITS  = 12;
    localparam int SEL_BITS       = 3;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 13'd16;
    localparam logic [STEP_BITS-1:0] STEP_MAX   = 13'd4096;
    localparam logic [STEP_BITS-1:0] STEP_MIN   = 13'd1;

    // divide order: first box motion x, y, z then second box motion x, y, z
    localparam logic [SEL_BITS-1:0] SEL_A_X = 3'd0;
    localparam logic [SEL_BITS-1:0] SEL_A_Y = 3'd1;
    localparam logic [SEL_BITS-1:0] SEL_A_Z = 3'd2;
    localparam logic [SEL_BITS-1:0] SEL_B_X = 3'd3;
    localparam logic [SEL_BITS-1:0] SEL_B_Y = 3'd4;
    localparam logic [SEL_BITS-1:0] SEL_B_Z = 3'd5;

    // first box store layout
    localparam int FB_POS_X  = 0;
    localparam int FB_POS_Y  = 1;
    localparam int FB_POS_Z  = 2;
    localparam int FB_SIZE_W = 3;
    localparam int FB_SIZE_H = 4;
    localparam int FB_SIZE_D = 5;
    localparam int FB_MOVE_X = 6;
    localparam int FB_MOVE_Y = 7;
    localparam int FB_MOVE_Z = 8;
    localparam int FB_FIELDS = 9;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_ADV  = 6'b000100,
        ST_TEST = 6'b001000,
        ST_FRAC = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

endpackage

/* src/swept_box_collision_time.sv */
// first box request: stored when accepted while idle, no result
// second box request: six motion divides, an advance of both boxes, then test steps up to the
//   step count, a fraction divide on a hit, then the output state
// DW = max(COORD_BITS, 12 + FRAC_BITS); all divides run on one bit-serial divider
// synchronous active-low reset clears control and step_count (16); first box store undefined
// ----------------------------------------------------------------------------
// swept_box_collision_time
// steps two moving boxes and reports the first overlapping sub-step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swept_box_collision_time
    import swbox_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_we,
    input  logic [STEP_BITS-1:0]         cfg_wdata,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_second_box,
    input  logic signed [COORD_BITS-1:0] s_pos_x,
    input  logic signed [COORD_BITS-1:0] s_pos_y,
    input  logic signed [COORD_BITS-1:0] s_pos_z,
    input  logic signed [COORD_BITS-1:0] s_size_w,
    input  logic signed [COORD_BITS-1:0] s_size_h,
    input  logic signed [COORD_BITS-1:0] s_size_d,
    input  logic signed [COORD_BITS-1:0] s_move_x,
    input  logic signed [COORD_BITS-1:0] s_move_y,
    input  logic signed [COORD_BITS-1:0] s_move_z,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit,
    output logic [HIT_STEP_BITS-1:0]     m_hit_step,
    output logic [FRAC_BITS:0]           m_hit_fraction
);

    localparam int POS_W = COORD_BITS + 2;
    localparam int DW    = (COORD_BITS > HIT_STEP_BITS + FRAC_BITS) ?
                           COORD_BITS : HIT_STEP_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    state_t state_reg, state_next;

    logic [STEP_BITS-1:0]         step_count_reg;
    logic [STEP_BITS-1:0]         steps_reg;
    logic [STEP_BITS-1:0]         steps_clamped;

    logic [COORD_BITS-1:0]        first_box_reg [FB_FIELDS];
    logic [COORD_BITS-1:0]        b_size_reg [3];
    logic [COORD_BITS-1:0]        b_move_reg [3];
    logic [COORD_BITS-1:0]        mv_reg [6];
    logic signed [POS_W-1:0]      pos_reg [6];

    logic [SEL_BITS-1:0]          div_sel_reg;
    logic [SEL_BITS-1:0]          src_idx;
    logic [COORD_BITS-1:0]        src_move;
    logic [COORD_BITS-1:0]        src_mag;
    logic [DW-1:0]                div_num_reg;
    logic [STEP_BITS-1:0]         div_rem_reg;
    logic                         div_neg_reg;
    logic [CNT_W-1:0]             div_cnt_reg;
    logic [STEP_BITS:0]           rem_sh;
    logic [STEP_BITS:0]           rem_new;
    logic                         q_bit;
    logic [COORD_BITS-1:0]        quot;
    logic [COORD_BITS-1:0]        mv_val;
    logic                         div_done;

    logic [HIT_STEP_BITS-1:0]     f_reg;
    logic                         last_step;
    logic                         overlap;
    logic                         res_hit_reg;

    logic signed [POS_W-1:0]      a_w, a_h, a_d, b_w, b_h, b_d;

    logic                         m_valid_reg;
    logic                         m_hit_reg;
    logic [HIT_STEP_BITS-1:0]     m_hit_step_reg;
    logic [FRAC_BITS:0]           m_hit_fraction_reg;
    logic                         out_load;
    logic                         in_req;

    assign s_ready        = (state_reg == ST_IDLE);
    assign in_req         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_hit_step     = m_hit_step_reg;
    assign m_hit_fraction = m_hit_fraction_reg;

    always_comb begin
        if (step_count_reg == '0) begin
            steps_clamped = STEP_MIN;
        end else if (step_count_reg > STEP_MAX) begin
            steps_clamped = STEP_MAX;
        end else begin
            steps_clamped = step_count_reg;
        end
    end

    // divider operand source
    assign src_idx = (state_reg == ST_IDLE) ? SEL_A_X : div_sel_reg + 1'b1;

    always_comb begin
        unique case (src_idx)
            SEL_A_X: src_move = first_box_reg[FB_MOVE_X];
            SEL_A_Y: src_move = first_box_reg[FB_MOVE_Y];
            SEL_A_Z: src_move = first_box_reg[FB_MOVE_Z];
            SEL_B_X: src_move = b_move_reg[0];
            SEL_B_Y: src_move = b_move_reg[1];
            SEL_B_Z: src_move = b_move_reg[2];
            default: src_move = '0;
        endcase
    end

    assign src_mag = src_move[COORD_BITS-1] ? (~src_move + 1'b1) : src_move;

    // shared restoring divider, one quotient bit per cycle
    assign rem_sh   = {div_rem_reg, div_num_reg[DW-1]};
    assign q_bit    = (rem_sh >= {1'b0, steps_reg});
    assign rem_new  = q_bit ? (rem_sh - {1'b0, steps_reg}) : rem_sh;
    assign div_done = (div_cnt_reg == '0);
    assign quot     = div_num_reg[COORD_BITS-1:0];
    assign mv_val   = div_neg_reg ? (~quot + 1'b1) : quot;

    // overlap test, height and depth extend downward
    assign a_w = {{(POS_W-COORD_BITS){first_box_reg[FB_SIZE_W][COORD_BITS-1]}},
                  first_box_reg[FB_SIZE_W]};
    assign a_h = {{(POS_W-COORD_BITS){first_box_reg[FB_SIZE_H][COORD_BITS-1]}},
                  first_box_reg[FB_SIZE_H]};
    assign a_d = {{(POS_W-COORD_BITS){first_box_reg[FB_SIZE_D][COORD_BITS-1]}},
                  first_box_reg[FB_SIZE_D]};
    assign b_w = {{(POS_W-COORD_BITS){b_size_reg[0][COORD_BITS-1]}}, b_size_reg[0]};
    assign b_h = {{(POS_W-COORD_BITS){b_size_reg[1][COORD_BITS-1]}}, b_size_reg[1]};
    assign b_d = {{(POS_W-COORD_BITS){b_size_reg[2][COORD_BITS-1]}}, b_size_reg[2]};

    assign overlap = (pos_reg[3] < pos_reg[0] + a_w) &&
                     (pos_reg[3] + b_w > pos_reg[0]) &&
                     (pos_reg[4] + b_h < pos_reg[1]) &&
                     (pos_reg[4] > pos_reg[1] + a_h) &&
                     (pos_reg[5] > pos_reg[2] + a_d) &&
                     (pos_reg[5] + b_d < pos_reg[2]);

    assign last_step = ({1'b0, f_reg} == steps_reg - 1'b1);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req && s_second_box) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done && div_sel_reg == SEL_B_Z) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (overlap) begin
                    state_next = ST_FRAC;
                end else if (last_step) begin
                    state_next = ST_OUT;
                end
            end
            ST_FRAC: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_count_reg <= STEP_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                step_count_reg <= cfg_wdata;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req && !s_second_box) begin
                    first_box_reg[FB_POS_X]  <= s_pos_x;
                    first_box_reg[FB_POS_Y]  <= s_pos_y;
                    first_box_reg[FB_POS_Z]  <= s_pos_z;
                    first_box_reg[FB_SIZE_W] <= s_size_w;
                    first_box_reg[FB_SIZE_H] <= s_size_h;
                    first_box_reg[FB_SIZE_D] <= s_size_d;
                    first_box_reg[FB_MOVE_X] <= s_move_x;
                    first_box_reg[FB_MOVE_Y] <= s_move_y;
                    first_box_reg[FB_MOVE_Z] <= s_move_z;
                end
                if (in_req && s_second_box) begin
                    steps_reg     <= steps_clamped;
                    b_size_reg[0] <= s_size_w;
                    b_size_reg[1] <= s_size_h;
                    b_size_reg[2] <= s_size_d;
                    b_move_reg[0] <= s_move_x;
                    b_move_reg[1] <= s_move_y;
                    b_move_reg[2] <= s_move_z;
                    pos_reg[0] <= {{(POS_W-COORD_BITS){first_box_reg[FB_POS_X][COORD_BITS-1]}},
                                   first_box_reg[FB_POS_X]};
                    pos_reg[1] <= {{(POS_W-COORD_BITS){first_box_reg[FB_POS_Y][COORD_BITS-1]}},
                                   first_box_reg[FB_POS_Y]};
                    pos_reg[2] <= {{(POS_W-COORD_BITS){first_box_reg[FB_POS_Z][COORD_BITS-1]}},
                                   first_box_reg[FB_POS_Z]};
                    pos_reg[3] <= {{(POS_W-COORD_BITS){s_pos_x[COORD_BITS-1]}}, s_pos_x};
                    pos_reg[4] <= {{(POS_W-COORD_BITS){s_pos_y[COORD_BITS-1]}}, s_pos_y};
                    pos_reg[5] <= {{(POS_W-COORD_BITS){s_pos_z[COORD_BITS-1]}}, s_pos_z};
                    div_sel_reg <= SEL_A_X;
                    div_num_reg <= DW'(src_mag);
                    div_neg_reg <= src_move[COORD_BITS-1];
                    div_rem_reg <= '0;
                    div_cnt_reg <= CNT_W'(DW);
                    f_reg       <= '0;
                    res_hit_reg <= 1'b0;
                end
            end
            ST_DIV: begin
                if (!div_done) begin
                    div_num_reg <= {div_num_reg[DW-2:0], q_bit};
                    div_rem_reg <= rem_new[STEP_BITS-1:0];
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end else begin
                    mv_reg[div_sel_reg] <= mv_val;
                    div_sel_reg <= div_sel_reg + 1'b1;
                    div_num_reg <= DW'(src_mag);
                    div_neg_reg <= src_move[COORD_BITS-1];
                    div_rem_reg <= '0;
                    div_cnt_reg <= CNT_W'(DW);
                end
            end
            ST_ADV: begin
                for (int i = 0; i < 6; i++) begin
                    pos_reg[i] <= pos_reg[i] +
                        {{(POS_W-COORD_BITS){mv_reg[i][COORD_BITS-1]}}, mv_reg[i]};
                end
            end
            ST_TEST: begin
                for (int i = 0; i < 6; i++) begin
                    pos_reg[i] <= pos_reg[i] +
                        {{(POS_W-COORD_BITS){mv_reg[i][COORD_BITS-1]}}, mv_reg[i]};
                end
                if (overlap) begin
                    res_hit_reg <= 1'b1;
                    div_num_reg <= DW'({f_reg, {FRAC_BITS{1'b0}}});
                    div_neg_reg <= 1'b0;
                    div_rem_reg <= '0;
                    div_cnt_reg <= CNT_W'(DW);
                end else if (!last_step) begin
                    f_reg <= f_reg + 1'b1;
                end
            end
            ST_FRAC: begin
                if (!div_done) begin
                    div_num_reg <= {div_num_reg[DW-2:0], q_bit};
                    div_rem_reg <= rem_new[STEP_BITS-1:0];
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_hit_reg          <= res_hit_reg;
                    m_hit_step_reg     <= res_hit_reg ? f_reg : '0;
                    m_hit_fraction_reg <= res_hit_reg ? div_num_reg[FRAC_BITS:0] : FRAC_ONE;
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_PAST(a_result_from_out, $rose(m_valid_reg), state_reg == ST_OUT, "result without output state")
    `ASSERT_IMPLY(a_miss_fields, m_valid_reg && !m_hit_reg, m_hit_step_reg == '0 && m_hit_fraction_reg == FRAC_ONE, "miss result fields wrong")
    `ASSERT_IMPLY(a_hit_fraction, m_valid_reg && m_hit_reg, m_hit_fraction_reg < FRAC_ONE, "hit fraction out of range")
    `ASSERT_IMPLY(a_div_count, state_reg == ST_DIV || state_reg == ST_FRAC, div_cnt_reg <= CNT_W'(DW), "divider count overrun")
    `ASSERT_IMPLY(a_step_bound, state_reg == ST_TEST, {1'b0, f_reg} < steps_reg, "sub-step beyond step count")

endmodule

/* bench/tb_swept_box_collision_time.sv */
// ----------------------------------------------------------------------------
// tb_swept_box_collision_time
// self-checking bench for the collision timer: box requests go in mostly as
// first/second pairs, second boxes without a table result are predicted by
// stepping both boxes in wide integer math, and every result is compared in
// order. a short directed table comes first, then random phases over several
// step counts, random idling on both sides, one long result stall, full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_swept_box_collision_time
    import swbox_pkg::*;
();

    localparam int CB = COORD_BITS_DEF;
    localparam int ONE_Q = 1 << FRAC_BITS_DEF;
    localparam int C_MAX = 32'sh7fff_ffff;
    localparam int C_MIN = 32'sh8000_0000;
    localparam int HOLD_CYCLES = 1500;
    localparam int N_PHASES = 9;

    typedef struct packed {
        logic                          second;
        logic [FB_FIELDS-1:0][CB-1:0]  fld;
    } box_req_t;

    typedef struct packed {
        logic                          hit;
        logic [HIT_STEP_BITS-1:0]      step;
        logic [FRAC_BITS_DEF:0]        frac;
    } sweep_result_t;

    typedef struct packed {
        box_req_t                      req;
        logic                          typed;
        sweep_result_t                 want;
    } table_row_t;

    localparam sweep_result_t NO_HIT   = '{1'b0, 12'd0, 17'h10000};
    localparam sweep_result_t HIT_AT_0 = '{1'b1, 12'd0, 17'd0};
    localparam sweep_result_t ANY      = '{1'b0, 12'd0, 17'd0};

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [STEP_BITS-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic s_second_box;
    logic signed [CB-1:0] s_pos_x, s_pos_y, s_pos_z;
    logic signed [CB-1:0] s_size_w, s_size_h, s_size_d;
    logic signed [CB-1:0] s_move_x, s_move_y, s_move_z;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    logic [HIT_STEP_BITS-1:0] m_hit_step;
    logic [FRAC_BITS_DEF:0] m_hit_fraction;

    box_req_t first_box_copy;
    logic [STEP_BITS-1:0] step_setting;
    sweep_result_t pending_sweeps[$];
    table_row_t directed_rows[$];

    int err_cnt = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_hits = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    bit hold_rx = 1'b0;

    always #5 aclk = ~aclk;

    swept_box_collision_time u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_second_box   (s_second_box),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_size_w       (s_size_w),
        .s_size_h       (s_size_h),
        .s_size_d       (s_size_d),
        .s_move_x       (s_move_x),
        .s_move_y       (s_move_y),
        .s_move_z       (s_move_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_hit_step     (m_hit_step),
        .m_hit_fraction (m_hit_fraction)
    );

    function automatic box_req_t mk_box(logic second, int px, int py, int pz,
                                        int w, int h, int d, int mx, int my, int mz);
        box_req_t r;
        r.second = second;
        r.fld[FB_POS_X] = px;
        r.fld[FB_POS_Y] = py;
        r.fld[FB_POS_Z] = pz;
        r.fld[FB_SIZE_W] = w;
        r.fld[FB_SIZE_H] = h;
        r.fld[FB_SIZE_D] = d;
        r.fld[FB_MOVE_X] = mx;
        r.fld[FB_MOVE_Y] = my;
        r.fld[FB_MOVE_Z] = mz;
        return r;
    endfunction

    // steps both boxes; height and depth extend downward
    function automatic sweep_result_t predict_first_contact(box_req_t a, box_req_t b,
                                                            logic [STEP_BITS-1:0] cfg);
        longint n;
        longint f;
        longint pa[FB_FIELDS];
        longint pb[FB_FIELDS];
        longint da[3];
        longint db[3];
        sweep_result_t r;
        n = longint'(cfg);
        if (n == 0) n = 1;
        if (n > STEP_MAX) n = STEP_MAX;
        for (int i = 0; i < FB_FIELDS; i++) begin
            pa[i] = $signed(a.fld[i]);
            pb[i] = $signed(b.fld[i]);
        end
        for (int i = 0; i < 3; i++) begin
            da[i] = pa[FB_MOVE_X + i] / n;
            db[i] = pb[FB_MOVE_X + i] / n;
        end
        r = NO_HIT;
        for (f = 0; f < n; f++) begin
            for (int i = 0; i < 3; i++) begin
                pa[FB_POS_X + i] += da[i];
                pb[FB_POS_X + i] += db[i];
            end
            if (pb[FB_POS_X] < pa[FB_POS_X] + pa[FB_SIZE_W] &&
                pb[FB_POS_X] + pb[FB_SIZE_W] > pa[FB_POS_X] &&
                pb[FB_POS_Y] + pb[FB_SIZE_H] < pa[FB_POS_Y] &&
                pb[FB_POS_Y] > pa[FB_POS_Y] + pa[FB_SIZE_H] &&
                pb[FB_POS_Z] > pa[FB_POS_Z] + pa[FB_SIZE_D] &&
                pb[FB_POS_Z] + pb[FB_SIZE_D] < pa[FB_POS_Z]) begin
                r.hit = 1'b1;
                r.step = f[HIT_STEP_BITS-1:0];
                r.frac = (FRAC_BITS_DEF + 1)'((f << FRAC_BITS_DEF) / n);
                return r;
            end
        end
        return r;
    endfunction

    // first box, then a second box that crosses it around mid-frame
    task automatic make_crossing_pair(output box_req_t a, output box_req_t b);
        int o;
        int sz;
        a.second = 1'b0;
        b.second = 1'b1;
        for (int i = 0; i < 3; i++) begin
            a.fld[FB_POS_X + i] = int'($urandom_range(0, 2000 * ONE_Q)) - 1000 * ONE_Q;
            a.fld[FB_MOVE_X + i] = int'($urandom_range(0, 512 * ONE_Q)) - 256 * ONE_Q;
            o = int'($urandom_range(0, 48 * ONE_Q)) - 24 * ONE_Q;
            b.fld[FB_POS_X + i] = a.fld[FB_POS_X + i] + o;
            b.fld[FB_MOVE_X + i] = a.fld[FB_MOVE_X + i] - 2 * o
                                   + int'($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
            sz = $urandom_range(ONE_Q / 4, 12 * ONE_Q);
            a.fld[FB_SIZE_W + i] = (i == 0) ? sz : -sz;
            if ($urandom_range(0, 7) == 0) a.fld[FB_SIZE_W + i] = -a.fld[FB_SIZE_W + i];
            sz = $urandom_range(ONE_Q / 4, 12 * ONE_Q);
            b.fld[FB_SIZE_W + i] = (i == 0) ? sz : -sz;
            if ($urandom_range(0, 7) == 0) b.fld[FB_SIZE_W + i] = -b.fld[FB_SIZE_W + i];
        end
    endtask

    task automatic drive_fields(box_req_t r);
        s_second_box = r.second;
        s_pos_x = r.fld[FB_POS_X];
        s_pos_y = r.fld[FB_POS_Y];
        s_pos_z = r.fld[FB_POS_Z];
        s_size_w = r.fld[FB_SIZE_W];
        s_size_h = r.fld[FB_SIZE_H];
        s_size_d = r.fld[FB_SIZE_D];
        s_move_x = r.fld[FB_MOVE_X];
        s_move_y = r.fld[FB_MOVE_Y];
        s_move_z = r.fld[FB_MOVE_Z];
    endtask

    task automatic send_request(box_req_t req, logic typed, sweep_result_t want);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        drive_fields(req);
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        n_requests++;
        if (!req.second) begin
            first_box_copy = req;
        end else begin
            pending_sweeps.push_back(typed ? want
                                     : predict_first_contact(first_box_copy, req, step_setting));
        end
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_sweeps.size() != 0) @(posedge aclk);
    endtask

    task automatic write_step_count(logic [STEP_BITS-1:0] value);
        wait_results_drained();
        repeat (8) @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        step_setting = value;
    endtask

    initial begin : stimulus
        int phase_steps[N_PHASES];
        int phase_len[N_PHASES];
        int sent;
        box_req_t a;
        box_req_t b;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        drive_fields('0);
        step_setting = STEP_RESET;
        first_box_copy = '0;

        // out-of-range step counts (0, 8191) clamp to 1 and 4096
        phase_steps = '{1, 4096, 5, 16, 200, 0, 8191, 4095, 3};
        phase_len = '{300, 16, 280, 280, 200, 60, 8, 8, 250};

        directed_rows.push_back('{mk_box(1'b0, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q, 0, 0, 0),
                                  1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q, 0, 0, 0),
                                  1'b1, HIT_AT_0});
        directed_rows.push_back('{mk_box(1'b1, 100 * ONE_Q, 0, 0, ONE_Q, -ONE_Q, -ONE_Q,
                                         0, 0, 0), 1'b1, NO_HIT});
        directed_rows.push_back('{mk_box(1'b1, -16 * ONE_Q, 0, 0, ONE_Q, -ONE_Q, -ONE_Q,
                                         16 * ONE_Q, 0, 0), 1'b1, '{1'b1, 12'd15, 17'd61440}});
        directed_rows.push_back('{mk_box(1'b1, -8 * ONE_Q, 0, 0, ONE_Q, -ONE_Q, -ONE_Q,
                                         8 * ONE_Q, 0, 0), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 0, 0, 0, ONE_Q, ONE_Q, -ONE_Q, 0, 0, 0),
                                  1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q, -17, 33, C_MIN),
                                  1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                                         C_MAX, C_MAX, C_MAX), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                                         C_MIN, C_MIN, C_MIN), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                         C_MAX, C_MAX, C_MAX), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b0, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                         C_MIN, C_MIN, C_MIN), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                         C_MIN, C_MIN, C_MIN), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, -1, -1, -1, -1, -1, -1, -1, -1, -1),
                                  1'b0, ANY});
        // repeated first boxes: the later one must win
        directed_rows.push_back('{mk_box(1'b0, 500 * ONE_Q, 500 * ONE_Q, 500 * ONE_Q, ONE_Q,
                                         -ONE_Q, -ONE_Q, 0, 0, 0), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b0, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q, 0, 0, 0),
                                  1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q, 0, 0, 0),
                                  1'b1, HIT_AT_0});
        directed_rows.push_back('{mk_box(1'b0, 0, 0, 0, ONE_Q, -ONE_Q, -ONE_Q,
                                         16 * ONE_Q, 0, 0), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 16 * ONE_Q, 0, 0, ONE_Q, -ONE_Q, -ONE_Q,
                                         0, 0, 0), 1'b0, ANY});
        directed_rows.push_back('{mk_box(1'b1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                                         32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa,
                                         32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555),
                                  1'b0, ANY});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < N_PHASES; p++) begin
            write_step_count(STEP_BITS'(phase_steps[p]));
            if (phase_steps[p] == 16) hold_rx = 1'b1;
            sent = 0;
            while (sent < phase_len[p]) begin
                if ($urandom_range(0, 9) < 8) begin
                    make_crossing_pair(a, b);
                    send_request(a, 1'b0, ANY);
                    send_request(b, 1'b0, ANY);
                    sent += 2;
                end else begin
                    a.second = 1'($urandom_range(0, 1));
                    for (int i = 0; i < FB_FIELDS; i++) a.fld[i] = $urandom();
                    send_request(a, 1'b0, ANY);
                    sent++;
                end
                if ($urandom_range(0, 199) == 0) wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (40) @(posedge aclk);
        $display("%0d box requests, %0d collision results checked (%0d hits)",
                 n_requests, n_results, n_hits);
        $display("step counts swept from 1 to 4096 plus clamped 0 and 8191");
        if (err_cnt == 0 && pending_sweeps.size() == 0) begin
            $display("swept_box_collision_time regression: pass");
        end else begin
            $display("swept_box_collision_time regression: fail");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (hold_rx) begin
                stall = HOLD_CYCLES;
                hold_rx = 1'b0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        sweep_result_t want;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (m_hit === 1'b1) n_hits++;
            if (pending_sweeps.size() == 0) begin
                $error("collision result with no request pending");
                err_cnt++;
            end else begin
                want = pending_sweeps.pop_front();
                if (m_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, m_hit);
                    err_cnt++;
                end
                if (m_hit_step !== want.step) begin
                    $error("hit_step: expected %0d, got %0d", want.step, m_hit_step);
                    err_cnt++;
                end
                if (m_hit_fraction !== want.frac) begin
                    $error("hit_fraction: expected %0d, got %0d", want.frac, m_hit_fraction);
                    err_cnt++;
                end
            end
        end
    end

    initial begin : watchdog
        #40_000_000;
        $display("swept_box_collision_time regression: fail");
        $finish;
    end

endmodule
